// ----- hdl/chmap_pkg.sv -----
// Shared types and constants of the chained hash map engine.
`timescale 1ns / 1ps
package chmap_pkg;

   localparam logic [1:0] CMD_SET    = 2'd0;
   localparam logic [1:0] CMD_GET    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

   localparam int unsigned HASH_SHIFT = 4;
   localparam int unsigned HASH_BITS  = 12;
   localparam logic [31:0] HASH_MULT  = 32'd2654435761;

   typedef struct packed {
      logic [1:0]           command;
      logic [63:0]          key;
      logic [63:0]          value;
      logic [HASH_BITS-1:0] bucket;
   } cmd_item_type;

endpackage

// ----- hdl/chmap_front.sv -----
// Front end: accepts command beats and attaches the hashed bucket.
`timescale 1ns / 1ps
module chmap_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [127:0]          req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  item_valid,
   input  logic                  item_ready,
   output chmap_pkg::cmd_item_type item
);
   import chmap_pkg::*;

   logic                   vld_ff;
   cmd_item_type           item_ff;
   cmd_item_type           item_in;
   logic [2*HASH_BITS-1:0] prod;

   // Only the low product bits select a bucket, so only the low key bits are needed.
   assign prod = req_tdata[HASH_SHIFT +: HASH_BITS] * HASH_MULT[HASH_BITS-1:0];

   always_comb begin
      item_in.command = req_tuser;
      item_in.key     = req_tdata[63:0];
      item_in.value   = req_tdata[127:64];
      item_in.bucket  = prod[HASH_BITS-1:0];
   end

   assign req_tready = !vld_ff || item_ready;
   assign item_valid = vld_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tready) begin
         vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- hdl/chmap_queue.sv -----
// Two-entry queue between the front end and the chain walker.
`timescale 1ns / 1ps
module chmap_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  chmap_pkg::cmd_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output chmap_pkg::cmd_item_type pop_item
);
   import chmap_pkg::*;

   cmd_item_type slot_ff [2];
   logic         wptr_ff;
   logic         rptr_ff;
   logic [1:0]   count_ff;
   logic         do_push;
   logic         do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/chmap_back.sv -----
// Back end: walks bucket chains in the entry pool and carries out each command.
`timescale 1ns / 1ps
module chmap_back #(
   parameter int unsigned BUCKETS = 64,
   parameter int unsigned ENTRIES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  chmap_pkg::cmd_item_type item,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,
   output logic [2:0]              rsp_tuser
);
   import chmap_pkg::*;

   localparam int unsigned HW = $clog2(BUCKETS);
   localparam int unsigned IW = $clog2(ENTRIES);
   localparam int unsigned LW = $clog2(ENTRIES + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_HEAD    = 3'd1;
   localparam logic [2:0] S_WALK    = 3'd2;
   localparam logic [2:0] S_RESOLVE = 3'd3;
   localparam logic [2:0] S_ALLOC   = 3'd4;
   localparam logic [2:0] S_FREE    = 3'd5;

   logic [LW-1:0] head_mem  [BUCKETS];
   logic [63:0]   key_mem   [ENTRIES];
   logic [63:0]   value_mem [ENTRIES];
   logic [LW-1:0] link_mem  [ENTRIES];

   logic [BUCKETS-1:0] head_valid_ff;
   logic [LW-1:0]      head_rd_ff;
   logic               head_vld_rd_ff;
   logic [63:0]        key_rd_ff;
   logic [63:0]        value_rd_ff;
   logic [LW-1:0]      link_rd_ff;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [63:0]   key_ff, key_in;
   logic [63:0]   val_ff, val_in;
   logic [HW-1:0] bkt_ff, bkt_in;
   logic [LW-1:0] chead_ff, chead_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] prev_ff, prev_in;
   logic [LW-1:0] steps_ff, steps_in;
   logic          hit_ff, hit_in;
   logic [LW-1:0] hit_link_ff, hit_link_in;
   logic [63:0]   hit_value_ff, hit_value_in;
   logic [LW-1:0] rec_head_ff, rec_head_in;
   logic [LW-1:0] fresh_ff, fresh_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic [2:0]    rsp_user_ff, rsp_user_in;

   logic          rsp_load;
   logic [1:0]    rsp_status;
   logic [HW-1:0] h_raddr;
   logic          h_we;
   logic [LW-1:0] h_wdata;
   logic [IW-1:0] e_raddr;
   logic          kv_we;
   logic [IW-1:0] kv_waddr;
   logic          l_we;
   logic [IW-1:0] l_waddr;
   logic [LW-1:0] l_wdata;
   logic [LW-1:0] head_now;

   assign head_now   = head_vld_rd_ff ? head_rd_ff : NULL_LINK;
   assign item_ready = state_ff == S_IDLE && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      bkt_in       = bkt_ff;
      chead_in     = chead_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      hit_in       = hit_ff;
      hit_link_in  = hit_link_ff;
      hit_value_in = hit_value_ff;
      rec_head_in  = rec_head_ff;
      fresh_in     = fresh_ff;
      rsp_load     = 1'b0;
      rsp_status   = STATUS_DONE;
      h_raddr      = item.bucket[HW-1:0];
      h_we         = 1'b0;
      h_wdata      = cur_ff;
      e_raddr      = cur_ff[IW-1:0];
      kv_we        = 1'b0;
      kv_waddr     = cur_ff[IW-1:0];
      l_we         = 1'b0;
      l_waddr      = prev_ff[IW-1:0];
      l_wdata      = hit_link_ff;
      case (state_ff)
         S_IDLE: begin
            if (item_valid && item_ready) begin
               cmd_in   = item.command;
               key_in   = item.key;
               val_in   = item.value;
               bkt_in   = item.bucket[HW-1:0];
               hit_in   = 1'b0;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            chead_in = head_now;
            prev_in  = NULL_LINK;
            cur_in   = head_now;
            if (cmd_ff == CMD_UNUSED) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else if (head_now >= NULL_LINK) begin
               state_in = S_RESOLVE;
            end else begin
               e_raddr  = head_now[IW-1:0];
               steps_in = LW'(1);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (key_rd_ff == key_ff) begin
               hit_in       = 1'b1;
               hit_link_in  = link_rd_ff;
               hit_value_in = value_rd_ff;
               state_in     = S_RESOLVE;
            end else if (link_rd_ff >= NULL_LINK || steps_ff == NULL_LINK) begin
               state_in = S_RESOLVE;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rd_ff;
               e_raddr  = link_rd_ff[IW-1:0];
               steps_in = steps_ff + LW'(1);
            end
         end
         S_RESOLVE: begin
            state_in = S_IDLE;
            case (cmd_ff)
               CMD_SET: begin
                  if (hit_ff) begin
                     kv_we    = 1'b1;
                     rsp_load = 1'b1;
                  end else if (rec_head_ff != NULL_LINK) begin
                     e_raddr  = rec_head_ff[IW-1:0];
                     state_in = S_ALLOC;
                  end else if (fresh_ff != NULL_LINK) begin
                     kv_we    = 1'b1;
                     kv_waddr = fresh_ff[IW-1:0];
                     l_we     = 1'b1;
                     l_waddr  = fresh_ff[IW-1:0];
                     l_wdata  = chead_ff;
                     h_we     = 1'b1;
                     h_wdata  = fresh_ff;
                     fresh_in = fresh_ff + LW'(1);
                     rsp_load = 1'b1;
                  end else begin
                     rsp_status = STATUS_POOL_FULL;
                     rsp_load   = 1'b1;
                  end
               end
               CMD_GET: begin
                  rsp_status = hit_ff ? STATUS_DONE : STATUS_NOT_FOUND;
                  rsp_load   = 1'b1;
               end
               default: begin
                  if (hit_ff) begin
                     if (prev_ff == NULL_LINK) begin
                        h_we    = 1'b1;
                        h_wdata = hit_link_ff;
                     end else begin
                        l_we = 1'b1;
                     end
                     state_in = S_FREE;
                  end else begin
                     rsp_status = STATUS_NOT_FOUND;
                     rsp_load   = 1'b1;
                  end
               end
            endcase
         end
         S_ALLOC: begin
            kv_we       = 1'b1;
            kv_waddr    = rec_head_ff[IW-1:0];
            l_we        = 1'b1;
            l_waddr     = rec_head_ff[IW-1:0];
            l_wdata     = chead_ff;
            h_we        = 1'b1;
            h_wdata     = rec_head_ff;
            rec_head_in = link_rd_ff;
            rsp_load    = 1'b1;
            state_in    = S_IDLE;
         end
         S_FREE: begin
            l_we        = 1'b1;
            l_waddr     = cur_ff[IW-1:0];
            l_wdata     = rec_head_ff;
            rec_head_in = cur_ff;
            rsp_load    = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (cmd_ff == CMD_GET && hit_ff) ? hit_value_ff : 64'd0;
         rsp_user_in  = (cmd_ff == CMD_UNUSED) ? {STATUS_DONE, 1'b0} : {rsp_status, hit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (h_we) begin
         head_mem[bkt_ff] <= h_wdata;
      end
      head_rd_ff     <= head_mem[h_raddr];
      head_vld_rd_ff <= head_valid_ff[h_raddr] && !reset;
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         key_mem[kv_waddr]   <= key_ff;
         value_mem[kv_waddr] <= val_ff;
      end
      key_rd_ff   <= key_mem[e_raddr];
      value_rd_ff <= value_mem[e_raddr];
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         link_mem[l_waddr] <= l_wdata;
      end
      link_rd_ff <= link_mem[e_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rec_head_ff   <= NULL_LINK;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         head_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rec_head_ff  <= rec_head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         if (h_we) begin
            head_valid_ff[bkt_ff] <= 1'b1;
         end
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      bkt_ff       <= bkt_in;
      chead_ff     <= chead_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      steps_ff     <= steps_in;
      hit_ff       <= hit_in;
      hit_link_ff  <= hit_link_in;
      hit_value_ff <= hit_value_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NULL_LINK)
      else $error("fresh entry count passed the pool size");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> cur_ff < NULL_LINK)
      else $error("chain walk on a null link");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrote a beat not yet taken");

   a_free_has_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FREE |-> hit_ff)
      else $error("entry freed without a match");

endmodule

// ----- hdl/chained_hash_map_engine_top.sv -----
// Top level of the chained hash map engine.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_tvalid/tready     tdata {value, key}, tuser command
//   rsp_      out        rsp_tvalid/tready     tdata read_value, tuser {status, found}
//
// A command holds the chain walker for a head read, one walk step per chain
// entry visited and a resolve step, plus an alloc step for an insert from a
// recycled entry or a free step for a remove hit; an unused command needs
// only the head read. Request and result beats are registered. Reset is
// synchronous and empties all buckets at once. Until full, the front end and
// a two-beat queue keep accepting while the walker works or the result beat waits.
// BUCKETS must be a power of two; the block itself does not enforce it.
`timescale 1ns / 1ps
module chained_hash_map_engine_top #(
   parameter int unsigned BUCKETS = 64,
   parameter int unsigned ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // key [63:0], value [127:64]
   input  logic [1:0]   req_tuser,   // command [1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // read_value [63:0]
   output logic [2:0]   rsp_tuser    // found [0], status [2:1]
);
   import chmap_pkg::*;

   logic         f_valid, f_ready, q_valid, q_ready;
   cmd_item_type f_item, q_item;

   chmap_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
   );

   chmap_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
   );

   chmap_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
      .clock(clock), .reset(reset),
      .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule
